@@ rtl/fms_pkg.sv @@
// ----------------------------------------------------------------------------
// fms_pkg
// Types, codes and constants shared by the flight mode sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fms_pkg;

   localparam int unsigned TICK_DIVIDE = 20;
   localparam int unsigned DIV_W       = $clog2(TICK_DIVIDE + 1);
   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [12:0]       ARM_THRESHOLD  = 13'd3000;
   localparam logic signed [9:0] WAGGLE_SIZE    = 10'sd300;
   localparam logic [8:0]        WAGGLE_COUNT   = 9'd4;
   localparam logic [8:0]        SAVE_ORIGIN_AT = 9'd6;
   localparam logic [8:0]        DEAD_RECKON_AT = 9'd2;

   localparam logic [7:0] CALIB_TICKS_RST   = 8'd21;
   localparam logic [7:0] STANDBY_TICKS_RST = 8'd96;
   localparam logic [7:0] LAUNCH_TICKS_RST  = 8'd40;

   localparam logic [2:0] REG_ALT_HOLD_STAB = 3'd0;
   localparam logic [2:0] REG_ALT_HOLD_WP   = 3'd1;
   localparam logic [2:0] REG_FS_MAIN_PLAN  = 3'd2;
   localparam logic [2:0] REG_FS_HOLD       = 3'd3;
   localparam logic [2:0] REG_CATAPULT_EN   = 3'd4;
   localparam logic [2:0] REG_CALIB_TICKS   = 3'd5;
   localparam logic [2:0] REG_STANDBY_TICKS = 3'd6;
   localparam logic [2:0] REG_LAUNCH_TICKS  = 3'd7;

   localparam logic [3:0] MODE_START    = 4'd0;
   localparam logic [3:0] MODE_CALIB    = 4'd1;
   localparam logic [3:0] MODE_ACQUIRE  = 4'd2;
   localparam logic [3:0] MODE_MANUAL   = 4'd3;
   localparam logic [3:0] MODE_STAB     = 4'd4;
   localparam logic [3:0] MODE_WAYPOINT = 4'd5;
   localparam logic [3:0] MODE_RETURN   = 4'd6;
   localparam logic [3:0] MODE_ARMED    = 4'd7;
   localparam logic [3:0] MODE_DELAY    = 4'd8;

   localparam logic [2:0] ACT_NONE         = 3'd0;
   localparam logic [2:0] ACT_CALIBRATE    = 3'd1;
   localparam logic [2:0] ACT_BEGIN_MAIN   = 3'd2;
   localparam logic [2:0] ACT_BEGIN_RTL    = 3'd3;
   localparam logic [2:0] ACT_INIT_MAIN    = 3'd4;
   localparam logic [2:0] ACT_HOLD_ALT     = 3'd5;
   localparam logic [2:0] ACT_CLEAR_LAUNCH = 3'd6;

   localparam logic [1:0] HOLD_PITCH = 2'd1;
   localparam logic [1:0] HOLD_FULL  = 2'd2;

   localparam logic [1:0] SW_MANUAL   = 2'd0;
   localparam logic [1:0] SW_STAB     = 2'd1;
   localparam logic [1:0] SW_WAYPOINT = 2'd2;

   typedef enum logic [8:0] {
      MS_START    = 9'b000000001,
      MS_CALIB    = 9'b000000010,
      MS_ACQUIRE  = 9'b000000100,
      MS_MANUAL   = 9'b000001000,
      MS_STAB     = 9'b000010000,
      MS_WAYPOINT = 9'b000100000,
      MS_RETURN   = 9'b001000000,
      MS_ARMED    = 9'b010000000,
      MS_DELAY    = 9'b100000000
   } mode_type;

   typedef struct packed {
      logic gps;
      logic pitch;
      logic aht;
      logic ahp;
      logic disthr;
      logic home_hold;
      logic dead_reckon;
   } flags_type;

   typedef struct packed {
      mode_type          mode;
      logic [DIV_W-1:0]  tick_div;
      logic [7:0]        calib_count;
      logic [8:0]        standby_count;
      logic [7:0]        launch_count;
      logic signed [9:0] waggle;
      flags_type         flags;
      logic              last_man_req;
      logic              red_led;
      logic              orange_led;
   } seq_state_type;

   typedef struct packed {
      logic [1:0] alt_hold_stab;
      logic [1:0] alt_hold_wp;
      logic       fs_main_plan;
      logic       fs_hold;
      logic       catapult_en;
      logic [7:0] calib_ticks;
      logic [7:0] standby_ticks;
      logic [7:0] launch_ticks;
   } cfg_type;

   function automatic logic [3:0] mode_code(input mode_type m);
      logic [3:0] code;
      unique case (m)
         MS_CALIB:    code = MODE_CALIB;
         MS_ACQUIRE:  code = MODE_ACQUIRE;
         MS_MANUAL:   code = MODE_MANUAL;
         MS_STAB:     code = MODE_STAB;
         MS_WAYPOINT: code = MODE_WAYPOINT;
         MS_RETURN:   code = MODE_RETURN;
         MS_ARMED:    code = MODE_ARMED;
         MS_DELAY:    code = MODE_DELAY;
         default:     code = MODE_START;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

@@ rtl/fms_step.sv @@
// ----------------------------------------------------------------------------
// fms_step
// Next-state logic of the mode machine for one tick: divider, async
// request, mode handler and mode entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fms_step (
   input  fms_pkg::seq_state_type state_cur,
   input  fms_pkg::cfg_type       cfg,
   input  logic                   radio_link,
   input  logic                   nav_usable,
   input  logic [1:0]             flight_sel,
   input  logic [12:0]            launch_arm_pulse,
   input  logic                   launch_fired,
   input  logic                   gps_startup_ok,
   input  logic                   mag_ready,
   input  logic                   radio_lost_event,
   output fms_pkg::seq_state_type state_nxt,
   output logic [2:0]             action,
   output logic                   origin_mark
);
   import fms_pkg::*;

   logic     sw_man;
   logic     sw_stab;
   logic     sw_wp;
   logic     arm_sig;
   logic     sync;
   logic     asap;
   logic     do_step;
   logic     enter_en;
   mode_type enter_mode;
   mode_type mode_old;
   logic [8:0] standby_dec;

   assign sw_man   = (flight_sel == SW_MANUAL);
   assign sw_stab  = (flight_sel == SW_STAB);
   assign sw_wp    = (flight_sel == SW_WAYPOINT);
   assign arm_sig  = (launch_arm_pulse > ARM_THRESHOLD);
   assign mode_old = state_cur.mode;
   assign sync     = (state_cur.tick_div >= DIV_W'(TICK_DIVIDE));
   assign asap     = radio_lost_event
                   | (cfg.catapult_en & ((sw_man != state_cur.last_man_req)
                                       | (launch_fired & (mode_old == MS_ARMED))
                                       | (mode_old == MS_DELAY)));
   assign do_step  = sync | asap;
   assign standby_dec = (state_cur.standby_count != '0)
                      ? state_cur.standby_count - 9'd1 : '0;

   always_comb begin
      state_nxt   = state_cur;
      action      = ACT_NONE;
      origin_mark = 1'b0;
      enter_en    = 1'b0;
      enter_mode  = MS_START;

      state_nxt.last_man_req = sw_man;
      if (sync) begin
         state_nxt.tick_div = '0;
      end else if (asap && cfg.catapult_en) begin
         state_nxt.tick_div = '0;
      end else begin
         state_nxt.tick_div = state_cur.tick_div + DIV_W'(1);
      end

      if (do_step) begin
         unique case (mode_old)
            MS_CALIB: begin
               if (radio_link) begin
                  state_nxt.red_led = ~state_cur.red_led;
                  if (state_cur.calib_count <= 8'd1) begin
                     state_nxt.calib_count = '0;
                     enter_en   = 1'b1;
                     enter_mode = MS_ACQUIRE;
                  end else begin
                     state_nxt.calib_count = state_cur.calib_count - 8'd1;
                  end
               end else begin
                  enter_en   = 1'b1;
                  enter_mode = MS_CALIB;
               end
            end
            MS_ACQUIRE: begin
               if (nav_usable && mag_ready && radio_link) begin
                  if (gps_startup_ok) begin
                     if (state_cur.standby_count == WAGGLE_COUNT + 9'd1) begin
                        state_nxt.waggle = WAGGLE_SIZE;
                     end else if (state_cur.standby_count <= WAGGLE_COUNT) begin
                        state_nxt.waggle = -state_cur.waggle;
                     end else begin
                        state_nxt.waggle = '0;
                     end
                     state_nxt.standby_count = standby_dec;
                     if (standby_dec == SAVE_ORIGIN_AT) begin
                        origin_mark = 1'b1;
                     end else if (standby_dec == DEAD_RECKON_AT) begin
                        state_nxt.flags.dead_reckon = 1'b1;
                     end else if (standby_dec == '0) begin
                        enter_en   = 1'b1;
                        enter_mode = MS_MANUAL;
                     end
                  end
               end else begin
                  state_nxt.waggle = '0;
               end
            end
            MS_MANUAL, MS_STAB: begin
               enter_en = 1'b1;
               if (radio_link) begin
                  if (cfg.catapult_en && arm_sig && sw_wp && nav_usable) begin
                     enter_mode = MS_ARMED;
                  end else if (sw_wp && nav_usable) begin
                     enter_mode = MS_WAYPOINT;
                  end else if (mode_old == MS_MANUAL && sw_stab) begin
                     enter_mode = MS_STAB;
                  end else if (mode_old == MS_STAB && sw_man) begin
                     enter_mode = MS_MANUAL;
                  end else begin
                     enter_en = 1'b0;
                  end
               end else if (nav_usable) begin
                  enter_mode = MS_RETURN;
               end else if (mode_old == MS_MANUAL) begin
                  enter_mode = MS_STAB;
               end else begin
                  enter_en = 1'b0;
               end
            end
            MS_WAYPOINT: begin
               state_nxt.red_led = ~state_cur.red_led;
               enter_en = 1'b1;
               if (radio_link) begin
                  if (sw_man) begin
                     enter_mode = MS_MANUAL;
                  end else if (sw_stab) begin
                     enter_mode = MS_STAB;
                  end else begin
                     enter_en = 1'b0;
                  end
               end else begin
                  enter_mode = MS_RETURN;
               end
            end
            MS_RETURN: begin
               if (radio_link) begin
                  enter_en = 1'b1;
                  if (sw_man) begin
                     enter_mode = MS_MANUAL;
                  end else if (sw_stab) begin
                     enter_mode = MS_STAB;
                  end else if (sw_wp && nav_usable) begin
                     enter_mode = MS_WAYPOINT;
                  end else begin
                     enter_en = 1'b0;
                  end
               end else if (cfg.fs_hold) begin
                  state_nxt.flags.home_hold = 1'b1;
               end
            end
            MS_ARMED: begin
               if (sw_man || !radio_link || !nav_usable) begin
                  state_nxt.orange_led = 1'b0;
                  enter_en   = 1'b1;
                  enter_mode = MS_MANUAL;
               end else if (launch_fired) begin
                  state_nxt.orange_led   = 1'b0;
                  state_nxt.launch_count = cfg.launch_ticks;
                  state_nxt.mode         = MS_DELAY;
               end
            end
            MS_DELAY: begin
               if (sw_man || !radio_link || !nav_usable) begin
                  state_nxt.orange_led = 1'b0;
                  enter_en   = 1'b1;
                  enter_mode = MS_MANUAL;
               end else if (state_cur.launch_count <= 8'd1) begin
                  state_nxt.launch_count = '0;
                  enter_en   = 1'b1;
                  enter_mode = MS_WAYPOINT;
               end else begin
                  state_nxt.launch_count = state_cur.launch_count - 8'd1;
               end
            end
            default: begin
               enter_en   = 1'b1;
               enter_mode = MS_CALIB;
            end
         endcase
      end

      if (enter_en) begin
         unique case (enter_mode)
            MS_CALIB: begin
               state_nxt.flags.gps   = 1'b0;
               state_nxt.flags.pitch = 1'b0;
               state_nxt.flags.aht   = 1'b0;
               state_nxt.flags.ahp   = 1'b0;
               state_nxt.waggle      = '0;
               state_nxt.calib_count = cfg.calib_ticks;
               state_nxt.red_led     = 1'b1;
               state_nxt.mode        = MS_CALIB;
            end
            MS_ACQUIRE: begin
               state_nxt.flags.gps     = 1'b0;
               state_nxt.flags.pitch   = 1'b0;
               state_nxt.flags.aht     = 1'b0;
               state_nxt.flags.ahp     = 1'b0;
               action                  = ACT_CALIBRATE;
               state_nxt.waggle        = WAGGLE_SIZE;
               state_nxt.standby_count = {1'b0, cfg.standby_ticks};
               state_nxt.red_led       = 1'b0;
               state_nxt.mode          = MS_ACQUIRE;
            end
            MS_MANUAL: begin
               state_nxt.flags.gps    = 1'b0;
               state_nxt.flags.pitch  = 1'b0;
               state_nxt.flags.aht    = 1'b0;
               state_nxt.flags.ahp    = 1'b0;
               state_nxt.flags.disthr = 1'b0;
               state_nxt.waggle       = '0;
               state_nxt.red_led      = 1'b0;
               state_nxt.mode         = MS_MANUAL;
            end
            MS_STAB: begin
               if (cfg.alt_hold_stab == HOLD_PITCH) begin
                  action = ACT_HOLD_ALT;
               end
               state_nxt.flags.gps   = 1'b0;
               state_nxt.flags.pitch = 1'b1;
               state_nxt.flags.aht   = (cfg.alt_hold_stab == HOLD_FULL);
               state_nxt.flags.ahp   = (cfg.alt_hold_stab == HOLD_FULL)
                                     | (cfg.alt_hold_stab == HOLD_PITCH);
               state_nxt.waggle      = '0;
               state_nxt.red_led     = 1'b1;
               state_nxt.mode        = MS_STAB;
            end
            MS_WAYPOINT: begin
               state_nxt.flags.disthr = 1'b0;
               state_nxt.flags.gps    = 1'b1;
               state_nxt.flags.pitch  = 1'b1;
               state_nxt.flags.aht    = (cfg.alt_hold_wp == HOLD_FULL);
               state_nxt.flags.ahp    = (cfg.alt_hold_wp == HOLD_FULL)
                                      | (cfg.alt_hold_wp == HOLD_PITCH);
               if (!(cfg.fs_main_plan && mode_old == MS_RETURN)) begin
                  action = ACT_BEGIN_MAIN;
               end
               state_nxt.waggle  = '0;
               state_nxt.red_led = 1'b1;
               state_nxt.mode    = MS_WAYPOINT;
            end
            MS_RETURN: begin
               state_nxt.flags.gps   = 1'b1;
               state_nxt.flags.pitch = 1'b1;
               state_nxt.flags.aht   = (cfg.alt_hold_wp == HOLD_FULL);
               state_nxt.flags.ahp   = (cfg.alt_hold_wp == HOLD_FULL)
                                     | (cfg.alt_hold_wp == HOLD_PITCH);
               if (cfg.fs_hold) begin
                  state_nxt.flags.home_hold = 1'b1;
               end
               if (!cfg.fs_main_plan) begin
                  action = ACT_BEGIN_RTL;
               end else if (mode_old != MS_WAYPOINT) begin
                  action = ACT_INIT_MAIN;
               end
               state_nxt.waggle  = '0;
               state_nxt.red_led = 1'b1;
               state_nxt.mode    = MS_RETURN;
            end
            MS_ARMED: begin
               action                 = ACT_CLEAR_LAUNCH;
               state_nxt.flags.disthr = 1'b1;
               state_nxt.orange_led   = 1'b1;
               state_nxt.mode         = MS_ARMED;
            end
            default: begin
               state_nxt.mode = state_nxt.mode;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/flight_mode_sequencer.sv @@
// ----------------------------------------------------------------------------
// flight_mode_sequencer
// Mode sequencer of a fixed-wing autopilot, one tick per request beat.
//
// req_* carries one tick beat (radio, GPS, switch, launch inputs). Each
// accepted beat steps the divider and, on the slow clock or an async
// request, the mode machine; one rsp_* beat follows with the mode, control
// flags, waggle offset, LEDs, one-shot action code and nav flags.
// rsp_valid rises in the cycle after acceptance; throughput is one beat per
// cycle while rsp_ready is high, set by the single registered state update.
// A stalled rsp beat holds in the result register; req_ready stays high
// while that register is empty or being drained in the same cycle.
// Reset (synchronous) puts the machine in start, clears flags, LEDs and the
// divider, reloads the timers with the register defaults and resets the
// csr_* registers. The csr_* port is an APB-style slave with registers at
// byte offsets 4*i; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module flight_mode_sequencer (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_radio_link,
   input  logic                             req_nav_usable,
   input  logic [1:0]                       req_flight_sel,
   input  logic [12:0]                      req_launch_arm_pulse,
   input  logic                             req_launch_fired,
   input  logic                             req_gps_startup_ok,
   input  logic                             req_mag_ready,
   input  logic                             req_radio_lost_event,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [3:0]                       rsp_mode,
   output logic                             rsp_nav_steer,
   output logic                             rsp_pitch_stab_en,
   output logic                             rsp_alt_hold_throttle,
   output logic                             rsp_alt_hold_pitch,
   output logic                             rsp_throttle_off,
   output logic                             rsp_home_hold,
   output logic signed [9:0]                rsp_waggle,
   output logic                             rsp_red_led,
   output logic                             rsp_orange_led,
   output logic [2:0]                       rsp_action,
   output logic [1:0]                       rsp_nav_flags,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import fms_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   seq_state_type state_ff;
   seq_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [3:0]    rsp_mode_ff;
   flags_type     rsp_flags_ff;
   logic signed [9:0] rsp_waggle_ff;
   logic          rsp_red_ff;
   logic          rsp_orange_ff;
   logic [2:0]    rsp_action_ff;
   logic [1:0]    rsp_nav_ff;
   logic [2:0]    step_action;
   logic          step_save;
   logic          accept;
   logic          csr_write;
   logic [2:0]    csr_index;

   fms_step u_step (
      .state_cur        (state_ff),
      .cfg              (cfg_ff),
      .radio_link       (req_radio_link),
      .nav_usable       (req_nav_usable),
      .flight_sel       (req_flight_sel),
      .launch_arm_pulse (req_launch_arm_pulse),
      .launch_fired     (req_launch_fired),
      .gps_startup_ok   (req_gps_startup_ok),
      .mag_ready        (req_mag_ready),
      .radio_lost_event (req_radio_lost_event),
      .state_nxt        (state_in),
      .action           (step_action),
      .origin_mark      (step_save)
   );

   assign req_ready    = ~rsp_valid_ff | rsp_ready;
   assign accept       = req_valid & req_ready;
   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ALT_HOLD_STAB: cfg_in.alt_hold_stab = csr_pwdata[1:0];
            REG_ALT_HOLD_WP:   cfg_in.alt_hold_wp   = csr_pwdata[1:0];
            REG_FS_MAIN_PLAN:  cfg_in.fs_main_plan  = csr_pwdata[0];
            REG_FS_HOLD:       cfg_in.fs_hold       = csr_pwdata[0];
            REG_CATAPULT_EN:   cfg_in.catapult_en   = csr_pwdata[0];
            REG_CALIB_TICKS:   cfg_in.calib_ticks   = csr_pwdata[7:0];
            REG_STANDBY_TICKS: cfg_in.standby_ticks = csr_pwdata[7:0];
            REG_LAUNCH_TICKS:  cfg_in.launch_ticks  = csr_pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ALT_HOLD_STAB: csr_prdata = {30'd0, cfg_ff.alt_hold_stab};
         REG_ALT_HOLD_WP:   csr_prdata = {30'd0, cfg_ff.alt_hold_wp};
         REG_FS_MAIN_PLAN:  csr_prdata = {31'd0, cfg_ff.fs_main_plan};
         REG_FS_HOLD:       csr_prdata = {31'd0, cfg_ff.fs_hold};
         REG_CATAPULT_EN:   csr_prdata = {31'd0, cfg_ff.catapult_en};
         REG_CALIB_TICKS:   csr_prdata = {24'd0, cfg_ff.calib_ticks};
         REG_STANDBY_TICKS: csr_prdata = {24'd0, cfg_ff.standby_ticks};
         REG_LAUNCH_TICKS:  csr_prdata = {24'd0, cfg_ff.launch_ticks};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alt_hold_stab <= '0;
         cfg_ff.alt_hold_wp   <= '0;
         cfg_ff.fs_main_plan  <= 1'b0;
         cfg_ff.fs_hold       <= 1'b0;
         cfg_ff.catapult_en   <= 1'b0;
         cfg_ff.calib_ticks   <= CALIB_TICKS_RST;
         cfg_ff.standby_ticks <= STANDBY_TICKS_RST;
         cfg_ff.launch_ticks  <= LAUNCH_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode          <= MS_START;
         state_ff.tick_div      <= '0;
         state_ff.calib_count   <= CALIB_TICKS_RST;
         state_ff.standby_count <= {1'b0, STANDBY_TICKS_RST};
         state_ff.launch_count  <= LAUNCH_TICKS_RST;
         state_ff.waggle        <= '0;
         state_ff.flags         <= '0;
         state_ff.last_man_req  <= 1'b0;
         state_ff.red_led       <= 1'b0;
         state_ff.orange_led    <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_mode_ff   <= mode_code(state_in.mode);
         rsp_flags_ff  <= state_in.flags;
         rsp_waggle_ff <= state_in.waggle;
         rsp_red_ff    <= state_in.red_led;
         rsp_orange_ff <= state_in.orange_led;
         rsp_action_ff <= step_action;
         rsp_nav_ff    <= {state_in.flags.dead_reckon, step_save};
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_mode              = rsp_mode_ff;
   assign rsp_nav_steer         = rsp_flags_ff.gps;
   assign rsp_pitch_stab_en     = rsp_flags_ff.pitch;
   assign rsp_alt_hold_throttle = rsp_flags_ff.aht;
   assign rsp_alt_hold_pitch    = rsp_flags_ff.ahp;
   assign rsp_throttle_off      = rsp_flags_ff.disthr;
   assign rsp_home_hold         = rsp_flags_ff.home_hold;
   assign rsp_waggle            = rsp_waggle_ff;
   assign rsp_red_led           = rsp_red_ff;
   assign rsp_orange_led        = rsp_orange_ff;
   assign rsp_action            = rsp_action_ff;
   assign rsp_nav_flags         = rsp_nav_ff;

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat produced no result");

   a_disthr_catapult: assert property (@(posedge clock) disable iff (reset)
      state_ff.flags.disthr |-> (state_ff.mode == MS_ARMED || state_ff.mode == MS_DELAY))
      else $error("throttle disabled outside catapult modes");

   a_waggle_acquire: assert property (@(posedge clock) disable iff (reset)
      (state_ff.waggle != '0) |-> (state_ff.mode == MS_ACQUIRE))
      else $error("waggle active outside acquire");

   a_origin_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nav_ff[0]) |-> (rsp_mode_ff == MODE_ACQUIRE))
      else $error("origin pulse outside acquire");

   a_divider_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff.tick_div <= DIV_W'(TICK_DIVIDE)))
      else $error("tick divider out of range");

endmodule

`default_nettype wire

@@ sim/tb_flight_mode_sequencer.sv @@
// ----------------------------------------------------------------------------
// tb_flight_mode_sequencer
// Self-checking bench for the flight mode sequencer. A driver and a monitor,
// both clocked, move tick beats in and status beats out under random idling
// on both sides, which one setting turns off. An in-bench predictor of the
// mode machine works out the status for each accepted tick and the monitor
// compares every field. The run walks start-up through calibration and GPS
// standby, then goes through several register settings. Each later setting
// gets launch sequences, quick mode walks and random noise.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_flight_mode_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import fms_pkg::*;

   localparam logic [1:0] SW_NONE = 2'd3;

   typedef struct packed {
      logic        radio_link;
      logic        nav_usable;
      logic [1:0]  flight_sel;
      logic [12:0] launch_arm_pulse;
      logic        launch_fired;
      logic        gps_startup_ok;
      logic        mag_ready;
      logic        radio_lost_event;
   } tick_type;

   typedef struct packed {
      logic [3:0]        mode;
      logic              nav_steer;
      logic              pitch_stab_en;
      logic              alt_hold_throttle;
      logic              alt_hold_pitch;
      logic              throttle_off;
      logic              home_hold;
      logic signed [9:0] waggle;
      logic              red_led;
      logic              orange_led;
      logic [2:0]        action;
      logic [1:0]        nav_flags;
   } status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0]        rsp_mode;
   logic              rsp_nav_steer;
   logic              rsp_pitch_stab_en;
   logic              rsp_alt_hold_throttle;
   logic              rsp_alt_hold_pitch;
   logic              rsp_throttle_off;
   logic              rsp_home_hold;
   logic signed [9:0] rsp_waggle;
   logic              rsp_red_led;
   logic              rsp_orange_led;
   logic [2:0]        rsp_action;
   logic [1:0]        rsp_nav_flags;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tick_type   cur_tick = '0;
   tick_type   tick_backlog[$];
   status_type status_due[$];
   status_type want_status;
   logic       req_taken = 1'b0;
   logic       no_idle   = 1'b0;

   int          errors       = 0;
   int          ticks_taken  = 0;
   int          beats_seen   = 0;
   int          settings_run = 0;
   logic [15:0] modes_seen   = '0;
   logic [7:0]  actions_seen = '0;

   // predicted sequencer state and register copy
   cfg_type           cfg;
   flags_type         flg;
   logic [3:0]        s_mode;
   int unsigned       s_div;
   logic [7:0]        s_calib_cnt;
   logic [8:0]        s_standby_cnt;
   logic [7:0]        s_launch_cnt;
   logic signed [9:0] s_waggle;
   logic              s_last_man;
   logic              s_red;
   logic              s_orange;
   logic [2:0]        s_act;
   logic              s_save;

   always #2 clock = ~clock;

   flight_mode_sequencer u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_radio_link        (cur_tick.radio_link),
      .req_nav_usable        (cur_tick.nav_usable),
      .req_flight_sel        (cur_tick.flight_sel),
      .req_launch_arm_pulse  (cur_tick.launch_arm_pulse),
      .req_launch_fired      (cur_tick.launch_fired),
      .req_gps_startup_ok    (cur_tick.gps_startup_ok),
      .req_mag_ready         (cur_tick.mag_ready),
      .req_radio_lost_event  (cur_tick.radio_lost_event),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_mode              (rsp_mode),
      .rsp_nav_steer         (rsp_nav_steer),
      .rsp_pitch_stab_en     (rsp_pitch_stab_en),
      .rsp_alt_hold_throttle (rsp_alt_hold_throttle),
      .rsp_alt_hold_pitch    (rsp_alt_hold_pitch),
      .rsp_throttle_off      (rsp_throttle_off),
      .rsp_home_hold         (rsp_home_hold),
      .rsp_waggle            (rsp_waggle),
      .rsp_red_led           (rsp_red_led),
      .rsp_orange_led        (rsp_orange_led),
      .rsp_action            (rsp_action),
      .rsp_nav_flags         (rsp_nav_flags),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   function automatic void reset_sequencer_model();
      cfg               = '0;
      cfg.calib_ticks   = CALIB_TICKS_RST;
      cfg.standby_ticks = STANDBY_TICKS_RST;
      cfg.launch_ticks  = LAUNCH_TICKS_RST;
      flg               = '0;
      s_mode            = MODE_START;
      s_div             = 0;
      s_calib_cnt       = CALIB_TICKS_RST;
      s_standby_cnt     = {1'b0, STANDBY_TICKS_RST};
      s_launch_cnt      = LAUNCH_TICKS_RST;
      s_waggle          = '0;
      s_last_man        = 1'b0;
      s_red             = 1'b0;
      s_orange          = 1'b0;
   endfunction

   function automatic void clear_auto();
      flg.gps   = 1'b0;
      flg.pitch = 1'b0;
      flg.aht   = 1'b0;
      flg.ahp   = 1'b0;
   endfunction

   function automatic void apply_hold(input logic [1:0] setting);
      if (setting == HOLD_FULL) begin
         flg.aht = 1'b1;
         flg.ahp = 1'b1;
      end else if (setting == HOLD_PITCH) begin
         flg.ahp = 1'b1;
      end
   endfunction

   function automatic void enter_calib();
      clear_auto();
      s_waggle    = '0;
      s_calib_cnt = cfg.calib_ticks;
      s_red       = 1'b1;
      s_mode      = MODE_CALIB;
   endfunction

   function automatic void enter_acquire();
      clear_auto();
      s_act         = ACT_CALIBRATE;
      s_waggle      = WAGGLE_SIZE;
      s_standby_cnt = {1'b0, cfg.standby_ticks};
      s_red         = 1'b0;
      s_mode        = MODE_ACQUIRE;
   endfunction

   function automatic void enter_manual();
      clear_auto();
      flg.disthr = 1'b0;
      s_waggle   = '0;
      s_red      = 1'b0;
      s_mode     = MODE_MANUAL;
   endfunction

   function automatic void enter_stab();
      if (cfg.alt_hold_stab == HOLD_PITCH) s_act = ACT_HOLD_ALT;
      clear_auto();
      flg.pitch = 1'b1;
      apply_hold(cfg.alt_hold_stab);
      s_waggle  = '0;
      s_red     = 1'b1;
      s_mode    = MODE_STAB;
   endfunction

   function automatic void enter_waypoint();
      clear_auto();
      flg.disthr = 1'b0;
      flg.gps    = 1'b1;
      flg.pitch  = 1'b1;
      apply_hold(cfg.alt_hold_wp);
      if (!(cfg.fs_main_plan && s_mode == MODE_RETURN)) s_act = ACT_BEGIN_MAIN;
      s_waggle = '0;
      s_red    = 1'b1;
      s_mode   = MODE_WAYPOINT;
   endfunction

   function automatic void enter_return();
      clear_auto();
      flg.gps   = 1'b1;
      flg.pitch = 1'b1;
      apply_hold(cfg.alt_hold_wp);
      if (cfg.fs_hold) flg.home_hold = 1'b1;
      if (!cfg.fs_main_plan) s_act = ACT_BEGIN_RTL;
      else if (s_mode != MODE_WAYPOINT) s_act = ACT_INIT_MAIN;
      s_waggle = '0;
      s_red    = 1'b1;
      s_mode   = MODE_RETURN;
   endfunction

   function automatic void enter_armed();
      s_act      = ACT_CLEAR_LAUNCH;
      flg.disthr = 1'b1;
      s_orange   = 1'b1;
      s_mode     = MODE_ARMED;
   endfunction

   // advance the sequencer by one tick and return the status it shows
   function automatic status_type step_sequencer(input tick_type t);
      status_type st;
      logic sw_man, sw_stab, sw_wp, armsig, man_req, asap, sync;
      sw_man  = (t.flight_sel == SW_MANUAL);
      sw_stab = (t.flight_sel == SW_STAB);
      sw_wp   = (t.flight_sel == SW_WAYPOINT);
      armsig  = (t.launch_arm_pulse > ARM_THRESHOLD);
      man_req = sw_man;
      s_act   = ACT_NONE;
      s_save  = 1'b0;
      asap    = t.radio_lost_event;
      if (cfg.catapult_en && (man_req != s_last_man ||
            (t.launch_fired && s_mode == MODE_ARMED) || s_mode == MODE_DELAY))
         asap = 1'b1;
      s_last_man = man_req;
      sync = (s_div >= TICK_DIVIDE);
      if (sync) s_div = 0;
      else s_div = s_div + 1;
      if (sync || asap) begin
         if (!sync && cfg.catapult_en) s_div = 0;
         case (s_mode)
            MODE_CALIB: begin
               if (t.radio_link) begin
                  s_red = ~s_red;
                  if (s_calib_cnt <= 8'd1) begin
                     s_calib_cnt = '0;
                     enter_acquire();
                  end else begin
                     s_calib_cnt = s_calib_cnt - 8'd1;
                  end
               end else begin
                  enter_calib();
               end
            end
            MODE_ACQUIRE: begin
               if (t.nav_usable && t.mag_ready && t.radio_link) begin
                  if (t.gps_startup_ok) begin
                     if (s_standby_cnt == WAGGLE_COUNT + 9'd1) s_waggle = WAGGLE_SIZE;
                     else if (s_standby_cnt <= WAGGLE_COUNT) s_waggle = -s_waggle;
                     else s_waggle = '0;
                     if (s_standby_cnt != 9'd0) s_standby_cnt = s_standby_cnt - 9'd1;
                     if (s_standby_cnt == SAVE_ORIGIN_AT) s_save = 1'b1;
                     else if (s_standby_cnt == DEAD_RECKON_AT) flg.dead_reckon = 1'b1;
                     else if (s_standby_cnt == 9'd0) enter_manual();
                  end
               end else begin
                  s_waggle = '0;
               end
            end
            MODE_MANUAL, MODE_STAB: begin
               if (t.radio_link) begin
                  if (cfg.catapult_en && armsig && sw_wp && t.nav_usable) enter_armed();
                  else if (sw_wp && t.nav_usable) enter_waypoint();
                  else if (s_mode == MODE_MANUAL && sw_stab) enter_stab();
                  else if (s_mode == MODE_STAB && sw_man) enter_manual();
               end else if (t.nav_usable) begin
                  enter_return();
               end else if (s_mode == MODE_MANUAL) begin
                  enter_stab();
               end
            end
            MODE_WAYPOINT: begin
               s_red = ~s_red;
               if (t.radio_link) begin
                  if (sw_man) enter_manual();
                  else if (sw_stab) enter_stab();
               end else begin
                  enter_return();
               end
            end
            MODE_RETURN: begin
               if (t.radio_link) begin
                  if (sw_man) enter_manual();
                  else if (sw_stab) enter_stab();
                  else if (sw_wp && t.nav_usable) enter_waypoint();
               end else if (cfg.fs_hold) begin
                  flg.home_hold = 1'b1;
               end
            end
            MODE_ARMED: begin
               if (sw_man || !t.radio_link || !t.nav_usable) begin
                  s_orange = 1'b0;
                  enter_manual();
               end else if (t.launch_fired) begin
                  s_orange     = 1'b0;
                  s_launch_cnt = cfg.launch_ticks;
                  s_mode       = MODE_DELAY;
               end
            end
            MODE_DELAY: begin
               if (sw_man || !t.radio_link || !t.nav_usable) begin
                  s_orange = 1'b0;
                  enter_manual();
               end else if (s_launch_cnt <= 8'd1) begin
                  s_launch_cnt = '0;
                  enter_waypoint();
               end else begin
                  s_launch_cnt = s_launch_cnt - 8'd1;
               end
            end
            default: enter_calib();
         endcase
      end
      st.mode              = s_mode;
      st.nav_steer         = flg.gps;
      st.pitch_stab_en     = flg.pitch;
      st.alt_hold_throttle = flg.aht;
      st.alt_hold_pitch    = flg.ahp;
      st.throttle_off      = flg.disthr;
      st.home_hold         = flg.home_hold;
      st.waggle            = s_waggle;
      st.red_led           = s_red;
      st.orange_led        = s_orange;
      st.action            = s_act;
      st.nav_flags         = {flg.dead_reckon, s_save};
      return st;
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // driver: hold a beat until taken, idle at random unless told not to
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (tick_backlog.size() != 0 && (no_idle || $urandom_range(99) >= 10)) begin
               cur_tick = tick_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         req_taken = 1'b0;
         rsp_ready <= no_idle || ($urandom_range(99) >= 10);
      end
   end

   // monitor: check status beats, predict on each accepted tick beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            if (!$isunknown(rsp_mode)) modes_seen[rsp_mode] = 1'b1;
            if (!$isunknown(rsp_action)) actions_seen[rsp_action] = 1'b1;
            if (status_due.size() == 0) begin
               $display("%0t: status beat with none expected, actual mode %0d",
                        $time, rsp_mode);
               errors++;
            end else begin
               want_status = status_due.pop_front();
               check_field("mode", want_status.mode, rsp_mode);
               check_field("nav_steer", want_status.nav_steer, rsp_nav_steer);
               check_field("pitch_stab_en", want_status.pitch_stab_en, rsp_pitch_stab_en);
               check_field("alt_hold_throttle", want_status.alt_hold_throttle,
                           rsp_alt_hold_throttle);
               check_field("alt_hold_pitch", want_status.alt_hold_pitch, rsp_alt_hold_pitch);
               check_field("throttle_off", want_status.throttle_off, rsp_throttle_off);
               check_field("home_hold", want_status.home_hold, rsp_home_hold);
               check_field("waggle", want_status.waggle, rsp_waggle);
               check_field("red_led", want_status.red_led, rsp_red_led);
               check_field("orange_led", want_status.orange_led, rsp_orange_led);
               check_field("action", want_status.action, rsp_action);
               check_field("nav_flags", want_status.nav_flags, rsp_nav_flags);
            end
         end
         if (req_valid && req_ready) begin
            status_due.push_back(step_sequencer(cur_tick));
            ticks_taken++;
            req_taken = 1'b1;
         end
      end
   end

   function automatic tick_type make_tick(input logic radio, input logic nav,
                                          input logic [1:0] sw, input logic [12:0] pulse,
                                          input logic launch, input logic gps,
                                          input logic mag, input logic lost);
      tick_type t;
      t.radio_link       = radio;
      t.nav_usable       = nav;
      t.flight_sel       = sw;
      t.launch_arm_pulse = pulse;
      t.launch_fired     = launch;
      t.gps_startup_ok   = gps;
      t.mag_ready        = mag;
      t.radio_lost_event = lost;
      return t;
   endfunction

   function automatic tick_type noise_tick();
      tick_type t;
      t.radio_link       = ($urandom_range(99) < 90);
      t.nav_usable       = ($urandom_range(99) < 85);
      t.flight_sel       = $urandom_range(3);
      t.launch_arm_pulse = ($urandom_range(3) == 0) ? $urandom_range(2998, 3003)
                                                    : $urandom_range(8191);
      t.launch_fired     = ($urandom_range(3) == 0);
      t.gps_startup_ok   = $urandom_range(1);
      t.mag_ready        = $urandom_range(1);
      t.radio_lost_event = ($urandom_range(9) == 0);
      return t;
   endfunction

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (tick_backlog.size() != 0 || req_valid || status_due.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_ALT_HOLD_STAB: cfg.alt_hold_stab = value[1:0];
         REG_ALT_HOLD_WP:   cfg.alt_hold_wp   = value[1:0];
         REG_FS_MAIN_PLAN:  cfg.fs_main_plan  = value[0];
         REG_FS_HOLD:       cfg.fs_hold       = value[0];
         REG_CATAPULT_EN:   cfg.catapult_en   = value[0];
         REG_CALIB_TICKS:   cfg.calib_ticks   = value[7:0];
         REG_STANDBY_TICKS: cfg.standby_ticks = value[7:0];
         REG_LAUNCH_TICKS:  cfg.launch_ticks  = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== value) begin
         $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
                  $time, idx, value, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_settings(input logic [1:0] ahs, input logic [1:0] ahw,
                                   input logic fs_main, input logic fs_hold,
                                   input logic cat, input logic [7:0] calib,
                                   input logic [7:0] standby, input logic [7:0] launch,
                                   input logic quiet);
      wait_drained();
      write_reg(REG_ALT_HOLD_STAB, ahs);
      write_reg(REG_ALT_HOLD_WP, ahw);
      write_reg(REG_FS_MAIN_PLAN, fs_main);
      write_reg(REG_FS_HOLD, fs_hold);
      write_reg(REG_CATAPULT_EN, cat);
      write_reg(REG_CALIB_TICKS, calib);
      write_reg(REG_STANDBY_TICKS, standby);
      write_reg(REG_LAUNCH_TICKS, launch);
      @(posedge clock);
      #1;
      no_idle = quiet;
      settings_run++;
   endtask

   task automatic queue_episodes(input int n_items);
      int added;
      int kind;
      int len;
      tick_type t;
      added = 0;
      while (added < n_items) begin
         kind = $urandom_range(9);
         if (kind < 4) begin
            // drop to manual, arm, launch, then ride out the delay
            t = noise_tick();
            t.radio_link = 1'b1;
            t.nav_usable = 1'b1;
            t.flight_sel = SW_MANUAL;
            t.radio_lost_event = 1'b1;
            tick_backlog.push_back(t);
            len = $urandom_range(1, 3);
            repeat (len) begin
               t = noise_tick();
               t.radio_link = 1'b1;
               t.nav_usable = 1'b1;
               t.flight_sel = SW_WAYPOINT;
               t.launch_arm_pulse = $urandom_range(3001, 8191);
               t.launch_fired = 1'b0;
               tick_backlog.push_back(t);
            end
            t = noise_tick();
            t.radio_link = 1'b1;
            t.nav_usable = 1'b1;
            t.flight_sel = SW_WAYPOINT;
            t.launch_fired = 1'b1;
            tick_backlog.push_back(t);
            added += len + 2;
            len = cfg.launch_ticks + $urandom_range(1, 3);
            repeat (len) begin
               t = noise_tick();
               t.radio_link = ($urandom_range(59) != 0);
               t.nav_usable = 1'b1;
               t.flight_sel = $urandom_range(1) ? SW_STAB : SW_WAYPOINT;
               tick_backlog.push_back(t);
            end
            added += len;
         end else if (kind < 7) begin
            len = $urandom_range(4, 10);
            repeat (len) begin
               t = noise_tick();
               t.radio_lost_event = 1'b1;
               tick_backlog.push_back(t);
            end
            added += len;
         end else begin
            len = $urandom_range(5, 30);
            repeat (len) tick_backlog.push_back(noise_tick());
            added += len;
         end
      end
   endtask

   initial begin
      reset_sequencer_model();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      program_settings(HOLD_PITCH, HOLD_FULL, 1'b0, 1'b1, 1'b0, 8'd2, 8'd8, 8'd1, 1'b0);
      // start-up: calibrate, restart on radio loss, then GPS standby to manual
      tick_backlog.push_back(make_tick(0, 0, SW_MANUAL, 13'd0, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(0, 0, SW_MANUAL, 13'd0, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(1, 0, SW_MANUAL, 13'd0, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(1, 0, SW_MANUAL, 13'd0, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(1, 1, SW_MANUAL, 13'd0, 0, 0, 1, 1));
      tick_backlog.push_back(make_tick(1, 0, SW_MANUAL, 13'd0, 0, 1, 1, 1));
      repeat (8) tick_backlog.push_back(make_tick(1, 1, SW_MANUAL, 13'h1FFF, 1, 1, 1, 1));
      // flight modes, switch value three, arm threshold edges
      tick_backlog.push_back(make_tick(1, 1, SW_STAB, 13'd3000, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(1, 1, SW_NONE, 13'd3001, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(1, 1, SW_WAYPOINT, 13'd8191, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(0, 1, SW_WAYPOINT, 13'd0, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(0, 0, SW_WAYPOINT, 13'd0, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(1, 1, SW_WAYPOINT, 13'd0, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(1, 1, SW_MANUAL, 13'd0, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(0, 0, SW_MANUAL, 13'd0, 0, 0, 0, 1));
      tick_backlog.push_back(make_tick(1, 1, SW_WAYPOINT, 13'd2999, 1, 1, 1, 0));

      program_settings(HOLD_FULL, HOLD_PITCH, 1'b1, 1'b0, 1'b1, 8'd255, 8'd255, 8'd1,
                       1'b0);
      queue_episodes(350);
      program_settings(2'd0, 2'd0, 1'b0, 1'b1, 1'b1, 8'd1, 8'd8, 8'd0, 1'b1);
      queue_episodes(350);
      program_settings(2'd3, 2'd3, 1'b1, 1'b1, 1'b1, 8'd21, 8'd96, 8'd255, 1'b0);
      queue_episodes(300);
      program_settings(HOLD_PITCH, HOLD_PITCH, 1'b0, 1'b0, 1'b0, 8'd7, 8'd20, 8'd17,
                       1'b0);
      queue_episodes(350);
      program_settings($urandom_range(2), $urandom_range(2), $urandom_range(1),
                       $urandom_range(1), 1'b1, $urandom_range(1, 255),
                       $urandom_range(8, 255), $urandom_range(1, 60), 1'b0);
      queue_episodes(350);

      wait_drained();
      $display("Checked %0d status beats for %0d tick beats over %0d register settings.",
               beats_seen, ticks_taken, settings_run);
      $display("Modes seen 0x%03h, action codes seen 0x%02h, mismatches %0d.",
               modes_seen, actions_seen, errors);
      if (errors == 0 && status_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout with %0d status beats still due", $time, status_due.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

@@ flight_mode_sequencer.f @@
rtl/fms_pkg.sv
rtl/fms_step.sv
rtl/flight_mode_sequencer.sv
sim/tb_flight_mode_sequencer.sv
